[hw/rtl/rmsl_pkg.sv]
// ----------------------------------------------------------------------------
// rmsl_pkg: shared types and constants
// widths, status codes, register indexes and the controller to datapath
// command and status groups of the running mean / stddev / limits unit
// ----------------------------------------------------------------------------
package rmsl_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int COUNT_W       = 13;
   localparam int SUM_W         = 28;
   localparam int SQSUM_W       = 43;
   localparam int MAX_SAMPLES   = 4096;
   localparam int FRACTION_BITS = 8;

   localparam int MEAN_W   = 24;
   localparam int SD_W     = 24;
   localparam int LIM_W    = 29;
   localparam int STATUS_W = 2;
   localparam int MULT_W   = 4;

   // abs(sum) scaled by the fraction bits, numerator of the mean division
   localparam int ABS_NUM_W = SUM_W + FRACTION_BITS;
   // n*sumsq - sum^2
   localparam int VAR_W     = 55;
   localparam int DIV_NUM_W = VAR_W + 2 * FRACTION_BITS;
   localparam int DEN_W     = 2 * COUNT_W;
   localparam int DIV_STEPS = DIV_NUM_W;

   localparam int SQ_LO_W = 22;
   localparam int SQ_HI_W = SQSUM_W - SQ_LO_W;

   // scaled variance stays below 2^48, so the root fits in 24 bits
   localparam int ROOT_IN_W  = 48;
   localparam int SQRT_STEPS = ROOT_IN_W / 2;

   localparam int ITER_W = $clog2(DIV_STEPS);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 152;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_POP_MODE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_MULT = 1'd1;

   localparam logic [MULT_W-1:0] LIMIT_MULT_RESET = 4'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic accum;
      logic setup;
      logic div_step;
      logic mean_fix;
      logic mul_hi;
      logic var_load;
      logic sqrt_load;
      logic sqrt_step;
      logic lim_mul;
      logic lim_add;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_den;
   } dp_status_type;

endpackage

[hw/rtl/running_mean_stddev_limits_unit.sv]
// ----------------------------------------------------------------------------
// running_mean_stddev_limits_unit: streaming mean, deviation and control limits
// one sample per cycle while accumulating; a last sample holds off input until rsp_tvalid
// (two 71-step restoring divisions and a 24-step root, or none for a single sample in
// sample mode). sync reset clears the store, mode 0, multiplier 3
// ----------------------------------------------------------------------------
module running_mean_stddev_limits_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample [15:0]
   input  logic [rmsl_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // mean_q8 [23:0], stddev_q8 [47:24], lower_limit_q8 [76:48],
   // upper_limit_q8 [105:77], minimum [121:106], maximum [137:122],
   // sample_count [150:138], zero [151]
   output logic [rmsl_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status [1:0]
   output logic [rmsl_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [rmsl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rmsl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic                          pop_mode_ff, pop_mode_in;
   logic [rmsl_pkg::MULT_W-1:0]   limit_mult_ff, limit_mult_in;

   rmsl_pkg::dp_cmd_type          cmd;
   rmsl_pkg::dp_status_type       sts;

   logic signed [rmsl_pkg::MEAN_W-1:0]   out_mean;
   logic [rmsl_pkg::SD_W-1:0]            out_sd;
   logic signed [rmsl_pkg::LIM_W-1:0]    out_lower;
   logic signed [rmsl_pkg::LIM_W-1:0]    out_upper;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] out_min;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] out_max;
   logic [rmsl_pkg::COUNT_W-1:0]         out_count;
   logic [rmsl_pkg::STATUS_W-1:0]        out_status;

   always_comb begin
      pop_mode_in   = pop_mode_ff;
      limit_mult_in = limit_mult_ff;
      if (csr_we) begin
         case (csr_index)
            rmsl_pkg::CSR_POP_MODE:   pop_mode_in   = csr_wdata[0];
            rmsl_pkg::CSR_LIMIT_MULT: limit_mult_in = csr_wdata[rmsl_pkg::MULT_W-1:0];
            default: begin
               pop_mode_in = pop_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_mode_ff   <= 1'b0;
         limit_mult_ff <= rmsl_pkg::LIMIT_MULT_RESET;
      end else begin
         pop_mode_ff   <= pop_mode_in;
         limit_mult_ff <= limit_mult_in;
      end
   end

   rmsl_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rmsl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample     ($signed(req_tdata[rmsl_pkg::SAMPLE_W-1:0])),
      .pop_mode   (pop_mode_ff),
      .limit_mult (limit_mult_ff),
      .sts        (sts),
      .out_mean   (out_mean),
      .out_sd     (out_sd),
      .out_lower  (out_lower),
      .out_upper  (out_upper),
      .out_min    (out_min),
      .out_max    (out_max),
      .out_count  (out_count),
      .out_status (out_status)
   );

   assign rsp_tdata = {1'b0, out_count, out_max, out_min, out_upper, out_lower,
                       out_sd, out_mean};
   assign rsp_tuser = out_status;

   // input stalls right after a last-sample transaction
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input accepted while computing a result");

   // a too-few result carries zero mean and deviation
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == rmsl_pkg::STATUS_FEW)) |-> (rsp_tdata[47:0] == '0))
      else $error("too-few result with nonzero statistics");

   // limits are ordered around the mean
   a_limit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[76:48]) <= $signed(rsp_tdata[105:77])))
      else $error("lower limit above upper limit");

   // count never exceeds capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[150:138] <= rmsl_pkg::COUNT_W'(rmsl_pkg::MAX_SAMPLES)))
      else $error("sample count beyond capacity");

endmodule

[hw/rtl/rmsl_datapath.sv]
// ----------------------------------------------------------------------------
// rmsl_datapath: accumulators and arithmetic
// running count, sum, sum of squares, min and max; a shared restoring divider,
// a bit-pair square root, limit arithmetic and the result payload register
// ----------------------------------------------------------------------------
module rmsl_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmsl_pkg::dp_cmd_type                 cmd,
   input  logic signed [rmsl_pkg::SAMPLE_W-1:0] sample,
   input  logic                                 pop_mode,
   input  logic [rmsl_pkg::MULT_W-1:0]          limit_mult,
   output rmsl_pkg::dp_status_type              sts,
   output logic signed [rmsl_pkg::MEAN_W-1:0]   out_mean,
   output logic [rmsl_pkg::SD_W-1:0]            out_sd,
   output logic signed [rmsl_pkg::LIM_W-1:0]    out_lower,
   output logic signed [rmsl_pkg::LIM_W-1:0]    out_upper,
   output logic signed [rmsl_pkg::SAMPLE_W-1:0] out_min,
   output logic signed [rmsl_pkg::SAMPLE_W-1:0] out_max,
   output logic [rmsl_pkg::COUNT_W-1:0]         out_count,
   output logic [rmsl_pkg::STATUS_W-1:0]        out_status
);

   localparam int MF_W    = rmsl_pkg::ABS_NUM_W + 2;
   localparam int PLO_W   = rmsl_pkg::COUNT_W + rmsl_pkg::SQ_LO_W;
   localparam int PHI_W   = rmsl_pkg::COUNT_W + rmsl_pkg::SQ_HI_W;
   localparam int SQR_W   = 2 * rmsl_pkg::SUM_W;
   localparam int LM_W    = rmsl_pkg::MULT_W + rmsl_pkg::SD_W;
   localparam int LSUM_W  = rmsl_pkg::LIM_W + 1;

   localparam logic signed [MF_W-1:0] MEAN_HI = MF_W'((2 ** (rmsl_pkg::MEAN_W - 1)) - 1);
   localparam logic signed [MF_W-1:0] MEAN_LO = MF_W'(-(2 ** (rmsl_pkg::MEAN_W - 1)));
   localparam logic signed [LSUM_W-1:0] LIM_HI = LSUM_W'((2 ** (rmsl_pkg::LIM_W - 1)) - 1);
   localparam logic signed [LSUM_W-1:0] LIM_LO = LSUM_W'(-(2 ** (rmsl_pkg::LIM_W - 1)));

   // accumulator store
   logic [rmsl_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic signed [rmsl_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rmsl_pkg::SQSUM_W-1:0]         sqsum_ff, sqsum_in;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] least_ff, least_in;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] greatest_ff, greatest_in;
   logic                                 dropped_ff, dropped_in;

   // working registers
   logic [rmsl_pkg::SUM_W-1:0]     abs_ff, abs_in;
   logic                           neg_ff, neg_in;
   logic [rmsl_pkg::DEN_W-1:0]     nd_ff, nd_in;
   logic [rmsl_pkg::DIV_NUM_W-1:0] div_num_ff, div_num_in;
   logic [rmsl_pkg::DEN_W-1:0]     div_rem_ff, div_rem_in;
   logic [rmsl_pkg::DEN_W-1:0]     div_den_ff, div_den_in;
   logic signed [rmsl_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic [rmsl_pkg::VAR_W-1:0]     prod_ff, prod_in;
   logic [rmsl_pkg::VAR_W-1:0]     sqr_ff, sqr_in;
   logic [rmsl_pkg::ROOT_IN_W-1:0] root_v_ff, root_v_in;
   logic [rmsl_pkg::ROOT_IN_W-1:0] root_res_ff, root_res_in;
   logic [rmsl_pkg::ROOT_IN_W-1:0] root_bit_ff, root_bit_in;
   logic [rmsl_pkg::SD_W-1:0]      sd_ff, sd_in;
   logic [LM_W-1:0]                lm_ff, lm_in;
   logic signed [rmsl_pkg::LIM_W-1:0] lo_ff, lo_in;
   logic signed [rmsl_pkg::LIM_W-1:0] hi_ff, hi_in;

   // result payload
   logic signed [rmsl_pkg::MEAN_W-1:0]   out_mean_ff, out_mean_in;
   logic [rmsl_pkg::SD_W-1:0]            out_sd_ff, out_sd_in;
   logic signed [rmsl_pkg::LIM_W-1:0]    out_lower_ff, out_lower_in;
   logic signed [rmsl_pkg::LIM_W-1:0]    out_upper_ff, out_upper_in;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] out_min_ff, out_min_in;
   logic signed [rmsl_pkg::SAMPLE_W-1:0] out_max_ff, out_max_in;
   logic [rmsl_pkg::COUNT_W-1:0]         out_count_ff, out_count_in;
   logic [rmsl_pkg::STATUS_W-1:0]        out_status_ff, out_status_in;

   // combinational helpers
   logic signed [2*rmsl_pkg::SAMPLE_W-1:0] sample_sq;
   logic [rmsl_pkg::COUNT_W-1:0]  den_d;
   logic [rmsl_pkg::SUM_W-1:0]    sum_abs;
   logic [rmsl_pkg::DEN_W:0]      div_trial;
   logic [rmsl_pkg::DEN_W:0]      div_diff;
   logic                          div_ge;
   logic [rmsl_pkg::ABS_NUM_W:0]  mean_mag;
   logic signed [MF_W-1:0]        mean_full;
   logic [PLO_W-1:0]              mul_lo;
   logic [PHI_W-1:0]              mul_hi;
   logic [SQR_W-1:0]              sqr_full;
   logic [rmsl_pkg::ROOT_IN_W-1:0] root_try;
   logic [rmsl_pkg::SD_W-1:0]     sd_sat;
   logic signed [LSUM_W-1:0]      lo_full;
   logic signed [LSUM_W-1:0]      hi_full;

   assign sample_sq = sample * sample;
   assign den_d     = pop_mode ? count_ff : count_ff - rmsl_pkg::COUNT_W'(1);
   assign sts.zero_den = (den_d == '0);
   assign sum_abs   = sum_ff[rmsl_pkg::SUM_W-1] ? rmsl_pkg::SUM_W'(-sum_ff)
                                                : rmsl_pkg::SUM_W'(sum_ff);

   assign div_trial = {div_rem_ff, div_num_ff[rmsl_pkg::DIV_NUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   // floor of a negative mean rounds the magnitude up
   assign mean_mag  = (rmsl_pkg::ABS_NUM_W + 1)'(div_num_ff[rmsl_pkg::ABS_NUM_W-1:0])
                    + (rmsl_pkg::ABS_NUM_W + 1)'(neg_ff && (div_rem_ff != '0));
   assign mean_full = neg_ff ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});

   assign mul_lo   = PLO_W'(count_ff) * PLO_W'(sqsum_ff[rmsl_pkg::SQ_LO_W-1:0]);
   assign mul_hi   = PHI_W'(count_ff) * PHI_W'(sqsum_ff[rmsl_pkg::SQSUM_W-1:rmsl_pkg::SQ_LO_W]);
   assign sqr_full = SQR_W'(abs_ff) * SQR_W'(abs_ff);

   assign root_try = root_res_ff + root_bit_ff;

   assign sd_sat = (root_res_ff[rmsl_pkg::ROOT_IN_W-1:rmsl_pkg::SD_W] != '0)
                 ? '1 : root_res_ff[rmsl_pkg::SD_W-1:0];

   assign lo_full = LSUM_W'(mean_ff) - $signed({2'b00, lm_ff});
   assign hi_full = LSUM_W'(mean_ff) + $signed({2'b00, lm_ff});

   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      sqsum_in    = sqsum_ff;
      least_in    = least_ff;
      greatest_in = greatest_ff;
      dropped_in  = dropped_ff;
      abs_in      = abs_ff;
      neg_in      = neg_ff;
      nd_in       = nd_ff;
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      mean_in     = mean_ff;
      prod_in     = prod_ff;
      sqr_in      = sqr_ff;
      root_v_in   = root_v_ff;
      root_res_in = root_res_ff;
      root_bit_in = root_bit_ff;
      sd_in       = sd_ff;
      lm_in       = lm_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      out_mean_in   = out_mean_ff;
      out_sd_in     = out_sd_ff;
      out_lower_in  = out_lower_ff;
      out_upper_in  = out_upper_ff;
      out_min_in    = out_min_ff;
      out_max_in    = out_max_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;

      if (cmd.accum) begin
         if (count_ff < rmsl_pkg::COUNT_W'(rmsl_pkg::MAX_SAMPLES)) begin
            count_in = count_ff + rmsl_pkg::COUNT_W'(1);
            sum_in   = sum_ff + rmsl_pkg::SUM_W'(sample);
            sqsum_in = sqsum_ff + rmsl_pkg::SQSUM_W'($unsigned(sample_sq));
            if (sample < least_ff) begin
               least_in = sample;
            end
            if (sample > greatest_ff) begin
               greatest_in = sample;
            end
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (cmd.setup) begin
         abs_in     = sum_abs;
         neg_in     = sum_ff[rmsl_pkg::SUM_W-1];
         nd_in      = rmsl_pkg::DEN_W'(count_ff) * rmsl_pkg::DEN_W'(den_d);
         div_num_in = rmsl_pkg::DIV_NUM_W'(sum_abs) << rmsl_pkg::FRACTION_BITS;
         div_rem_in = '0;
         div_den_in = rmsl_pkg::DEN_W'(count_ff);
      end

      if (cmd.div_step) begin
         div_num_in = {div_num_ff[rmsl_pkg::DIV_NUM_W-2:0], div_ge};
         div_rem_in = div_ge ? div_diff[rmsl_pkg::DEN_W-1:0] : div_trial[rmsl_pkg::DEN_W-1:0];
      end

      if (cmd.mean_fix) begin
         if (mean_full > MEAN_HI) begin
            mean_in = rmsl_pkg::MEAN_W'(MEAN_HI);
         end else if (mean_full < MEAN_LO) begin
            mean_in = rmsl_pkg::MEAN_W'(MEAN_LO);
         end else begin
            mean_in = rmsl_pkg::MEAN_W'(mean_full);
         end
         prod_in = rmsl_pkg::VAR_W'(mul_lo);
         sqr_in  = sqr_full[rmsl_pkg::VAR_W-1:0];
      end

      if (cmd.mul_hi) begin
         prod_in = prod_ff + (rmsl_pkg::VAR_W'(mul_hi) << rmsl_pkg::SQ_LO_W);
      end

      if (cmd.var_load) begin
         div_num_in = rmsl_pkg::DIV_NUM_W'(prod_ff - sqr_ff) << (2 * rmsl_pkg::FRACTION_BITS);
         div_rem_in = '0;
         div_den_in = nd_ff;
      end

      if (cmd.sqrt_load) begin
         root_v_in   = div_num_ff[rmsl_pkg::ROOT_IN_W-1:0];
         root_res_in = '0;
         root_bit_in = rmsl_pkg::ROOT_IN_W'(1) << (rmsl_pkg::ROOT_IN_W - 2);
      end

      if (cmd.sqrt_step) begin
         if (root_v_ff >= root_try) begin
            root_v_in   = root_v_ff - root_try;
            root_res_in = (root_res_ff >> 1) + root_bit_ff;
         end else begin
            root_res_in = root_res_ff >> 1;
         end
         root_bit_in = root_bit_ff >> 2;
      end

      if (cmd.lim_mul) begin
         sd_in = sd_sat;
         lm_in = LM_W'(limit_mult) * LM_W'(sd_sat);
      end

      if (cmd.lim_add) begin
         if (lo_full > LIM_HI) begin
            lo_in = rmsl_pkg::LIM_W'(LIM_HI);
         end else if (lo_full < LIM_LO) begin
            lo_in = rmsl_pkg::LIM_W'(LIM_LO);
         end else begin
            lo_in = rmsl_pkg::LIM_W'(lo_full);
         end
         if (hi_full > LIM_HI) begin
            hi_in = rmsl_pkg::LIM_W'(LIM_HI);
         end else if (hi_full < LIM_LO) begin
            hi_in = rmsl_pkg::LIM_W'(LIM_LO);
         end else begin
            hi_in = rmsl_pkg::LIM_W'(hi_full);
         end
      end

      if (cmd.out_load) begin
         out_count_in = count_ff;
         if (sts.zero_den) begin
            out_mean_in   = '0;
            out_sd_in     = '0;
            out_lower_in  = '0;
            out_upper_in  = '0;
            out_min_in    = '0;
            out_max_in    = '0;
            out_status_in = rmsl_pkg::STATUS_FEW;
         end else begin
            out_mean_in   = mean_ff;
            out_sd_in     = sd_ff;
            out_lower_in  = lo_ff;
            out_upper_in  = hi_ff;
            out_min_in    = least_ff;
            out_max_in    = greatest_ff;
            out_status_in = dropped_ff ? rmsl_pkg::STATUS_DROPPED : rmsl_pkg::STATUS_OK;
         end
         // store starts over for the next set
         count_in    = '0;
         sum_in      = '0;
         sqsum_in    = '0;
         least_in    = 16'sh7FFF;
         greatest_in = 16'sh8000;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         sqsum_ff    <= '0;
         least_ff    <= 16'sh7FFF;
         greatest_ff <= 16'sh8000;
         dropped_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sqsum_ff    <= sqsum_in;
         least_ff    <= least_in;
         greatest_ff <= greatest_in;
         dropped_ff  <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_ff      <= abs_in;
      neg_ff      <= neg_in;
      nd_ff       <= nd_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      sqr_ff      <= sqr_in;
      root_v_ff   <= root_v_in;
      root_res_ff <= root_res_in;
      root_bit_ff <= root_bit_in;
      sd_ff       <= sd_in;
      lm_ff       <= lm_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      out_mean_ff   <= out_mean_in;
      out_sd_ff     <= out_sd_in;
      out_lower_ff  <= out_lower_in;
      out_upper_ff  <= out_upper_in;
      out_min_ff    <= out_min_in;
      out_max_ff    <= out_max_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   assign out_mean   = out_mean_ff;
   assign out_sd     = out_sd_ff;
   assign out_lower  = out_lower_ff;
   assign out_upper  = out_upper_ff;
   assign out_min    = out_min_ff;
   assign out_max    = out_max_ff;
   assign out_count  = out_count_ff;
   assign out_status = out_status_ff;

endmodule

[hw/rtl/rmsl_controller.sv]
// ----------------------------------------------------------------------------
// rmsl_controller: sequencing state machine
// takes samples while accumulating, steps the datapath through the final
// divisions and square root, and owns the result valid flag
// ----------------------------------------------------------------------------
module rmsl_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  rmsl_pkg::dp_status_type sts,
   output rmsl_pkg::dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_ACCUM     = 12'b0000_0000_0001,
      S_SETUP     = 12'b0000_0000_0010,
      S_DIV_MEAN  = 12'b0000_0000_0100,
      S_MEAN_FIX  = 12'b0000_0000_1000,
      S_MUL_HI    = 12'b0000_0001_0000,
      S_VAR_LOAD  = 12'b0000_0010_0000,
      S_DIV_VAR   = 12'b0000_0100_0000,
      S_SQRT_LOAD = 12'b0000_1000_0000,
      S_SQRT      = 12'b0001_0000_0000,
      S_LIM_MUL   = 12'b0010_0000_0000,
      S_LIM_ADD   = 12'b0100_0000_0000,
      S_FINISH    = 12'b1000_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [rmsl_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_ACCUM);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      iter_in  = '0;
      cmd      = '0;
      case (state_ff)
         S_ACCUM: begin
            cmd.accum = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.zero_den ? S_FINISH : S_DIV_MEAN;
         end
         S_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + rmsl_pkg::ITER_W'(1);
            if (iter_ff == rmsl_pkg::ITER_W'(rmsl_pkg::DIV_STEPS - 1)) begin
               state_in = S_MEAN_FIX;
            end
         end
         S_MEAN_FIX: begin
            cmd.mean_fix = 1'b1;
            state_in     = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_VAR_LOAD;
         end
         S_VAR_LOAD: begin
            cmd.var_load = 1'b1;
            state_in     = S_DIV_VAR;
         end
         S_DIV_VAR: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + rmsl_pkg::ITER_W'(1);
            if (iter_ff == rmsl_pkg::ITER_W'(rmsl_pkg::DIV_STEPS - 1)) begin
               state_in = S_SQRT_LOAD;
            end
         end
         S_SQRT_LOAD: begin
            cmd.sqrt_load = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + rmsl_pkg::ITER_W'(1);
            if (iter_ff == rmsl_pkg::ITER_W'(rmsl_pkg::SQRT_STEPS - 1)) begin
               state_in = S_LIM_MUL;
            end
         end
         S_LIM_MUL: begin
            cmd.lim_mul = 1'b1;
            state_in    = S_LIM_ADD;
         end
         S_LIM_ADD: begin
            cmd.lim_add = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // hold until the previous result has left the output register
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
